[rtl/core/tks_pkg.sv]
// Shared types and constants for the streaming top-k selector.
// No dependencies; every other file refers to it by scoped names.
package tks_pkg;

    localparam int VALUE_W      = 32;
    localparam int RANK_W       = 4;
    localparam int CNT_W        = 5;
    localparam int MAX_KEEP_DEF = 16;
    // the result channel ranks at most this many values
    localparam int RESULT_LIMIT = 16;
    localparam logic [CNT_W-1:0] KEEP_RESET = 5'd16;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic                      insert;
        logic                      shift;
        logic signed [VALUE_W-1:0] sample;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_COLLECT = 2'b01,
        S_DRAIN   = 2'b10
    } state_t;

endpackage

[rtl/core/tks_ifs.sv]
// Channel interfaces of the top-k selector: samples, results, configuration.
// Depends on tks_pkg for field widths.
interface tks_sample_if;
    logic                               valid;
    logic                               ready;
    logic signed [tks_pkg::VALUE_W-1:0] sample_value;
    logic                               end_of_set;

    modport source (output valid, output sample_value, output end_of_set, input ready);
    modport sink (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface tks_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [tks_pkg::VALUE_W-1:0] kept_value;
    logic [tks_pkg::RANK_W-1:0]         rank;
    logic                               short_stream;
    logic                               last_result;

    modport source (output valid, output kept_value, output rank, output short_stream,
                    output last_result, input ready);
    modport sink (input valid, input kept_value, input rank, input short_stream,
                  input last_result, output ready);
endinterface

interface tks_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tks_pkg::CNT_W-1:0]        data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/tks_cell.sv]
// One cell of the sorted chain: holds one kept value, inserts or shifts.
// Depends on tks_pkg for cell_ctrl_t and the value width.
module tks_cell
(
    input  logic                               clk,
    input  tks_pkg::cell_ctrl_t                ctrl,
    input  logic                               occupied,
    input  logic                               left_ge,
    input  logic signed [tks_pkg::VALUE_W-1:0] left_value,
    input  logic signed [tks_pkg::VALUE_W-1:0] right_value,
    output logic signed [tks_pkg::VALUE_W-1:0] value,
    output logic                               ge
);

    logic signed [tks_pkg::VALUE_W-1:0] value_reg;
    logic signed [tks_pkg::VALUE_W-1:0] value_next;

    // a held value at least the sample stays ahead of it
    assign ge = occupied && (value_reg >= ctrl.sample);

    // keep, take the sample, take the left neighbor, or take the right one
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (!ge)
            begin
                value_next = left_ge ? ctrl.sample : left_value;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[rtl/core/streaming_top_k_select.sv]
// Streaming top-k selector: sample channel in, ranked result channel out.
// Depends on tks_pkg, the channel interfaces and tks_cell.
//
// Use: write keep_count (k, 1..16, reset 16) on cfg while the block is idle;
// a write also empties the store. Send values on samples; the store keeps the
// k largest in a chain of compare cells, one value inserted per cycle, so the
// sample channel takes one transaction every cycle while a set streams in.
// The transaction with end_of_set is inserted too, then the chain drains from
// its head: one result per cycle while the receiver is ready, largest first,
// rank counting from 0, last_result on the final one, short_stream set on all
// results when fewer than k values arrived. Each result is loaded from the
// chain head into the output register; samples.ready stays low for the whole
// drain, also while the receiver stalls, as each shift of the chain waits for
// the output register to free up. The next set may start while the final
// result still waits in the output register.
// Reset empties the store and sets k to 16; no clearing pass is needed.
module streaming_top_k_select
#(
    parameter int MAX_KEEP = tks_pkg::MAX_KEEP_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    tks_sample_if.sink    samples,
    tks_result_if.source  results,
    tks_cfg_if.sink       cfg
);

    localparam int NCELL = (MAX_KEEP < tks_pkg::RESULT_LIMIT) ? MAX_KEEP
                                                               : tks_pkg::RESULT_LIMIT;
    localparam int CW = $clog2(NCELL + 1);
    localparam int IW = (NCELL > 1) ? $clog2(NCELL) : 1;

    tks_pkg::state_t            state_reg, state_next;
    logic [tks_pkg::CNT_W-1:0]  keep_count_reg, keep_count_next;
    logic [CW-1:0]              fill_reg, fill_next;
    logic [CW-1:0]              remain_reg, remain_next;
    logic [tks_pkg::RANK_W-1:0] rank_reg, rank_next;
    logic                       short_reg, short_next;

    logic                               out_valid_reg, out_valid_next;
    logic signed [tks_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic [tks_pkg::RANK_W-1:0]         out_rank_reg, out_rank_next;
    logic                               out_short_reg, out_short_next;
    logic                               out_last_reg, out_last_next;

    logic [CW-1:0]              k_eff;
    logic [IW-1:0]              k_last;
    logic                       full;
    logic                       in_fire;
    logic                       load;
    logic [CW-1:0]              fill_after;
    tks_pkg::cell_ctrl_t        ctrl;

    logic [NCELL-1:0]                   cell_ge;
    logic [NCELL-1:0]                   cell_occ;
    logic signed [tks_pkg::VALUE_W-1:0] cell_value [NCELL];

    // clamp k to 1 .. number of cells
    always_comb
    begin
        if (keep_count_reg == '0)
        begin
            k_eff = CW'(1);
        end
        else if (keep_count_reg > tks_pkg::CNT_W'(NCELL))
        begin
            k_eff = CW'(NCELL);
        end
        else
        begin
            k_eff = keep_count_reg[CW-1:0];
        end
    end

    assign k_last     = IW'(k_eff - CW'(1));
    assign full       = (fill_reg == k_eff);
    assign fill_after = full ? fill_reg : fill_reg + CW'(1);

    assign samples.ready = (state_reg == tks_pkg::S_COLLECT);
    assign cfg.ready     = 1'b1;
    assign in_fire       = samples.valid && samples.ready;
    assign load          = (state_reg == tks_pkg::S_DRAIN) && (!out_valid_reg || results.ready);

    // insert while filling or if the sample beats the smallest; shift on loads
    always_comb
    begin
        ctrl.sample = samples.sample_value;
        ctrl.insert = in_fire && (!full || !cell_ge[k_last]);
        ctrl.shift  = load;
    end

    // build the chain of cells
    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            logic                               left_ge;
            logic signed [tks_pkg::VALUE_W-1:0] left_value;
            logic signed [tks_pkg::VALUE_W-1:0] right_value;

            assign cell_occ[g] = (fill_reg > CW'(g));

            if (g == 0)
            begin : g_head
                assign left_ge    = 1'b1;
                assign left_value = '0;
            end
            else
            begin : g_body
                assign left_ge    = cell_ge[g-1];
                assign left_value = cell_value[g-1];
            end

            if (g == NCELL - 1)
            begin : g_tail
                assign right_value = '0;
            end
            else
            begin : g_mid
                assign right_value = cell_value[g+1];
            end

            tks_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (cell_occ[g]),
                .left_ge     (left_ge),
                .left_value  (left_value),
                .right_value (right_value),
                .value       (cell_value[g]),
                .ge          (cell_ge[g])
            );
        end
    endgenerate

    // sequence collection and drain, and advance the output register
    always_comb
    begin
        state_next      = state_reg;
        keep_count_next = keep_count_reg;
        fill_next       = fill_reg;
        remain_next     = remain_reg;
        rank_next       = rank_reg;
        short_next      = short_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_rank_next   = out_rank_reg;
        out_short_next  = out_short_reg;
        out_last_next   = out_last_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tks_pkg::S_COLLECT:
            begin
                if (in_fire)
                begin
                    fill_next = fill_after;
                    if (samples.end_of_set)
                    begin
                        remain_next = fill_after;
                        rank_next   = '0;
                        short_next  = (fill_after != k_eff);
                        state_next  = tks_pkg::S_DRAIN;
                    end
                end
            end
            tks_pkg::S_DRAIN:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = cell_value[0];
                    out_rank_next  = rank_reg;
                    out_short_next = short_reg;
                    out_last_next  = (remain_reg == CW'(1));
                    remain_next    = remain_reg - CW'(1);
                    rank_next      = rank_reg + tks_pkg::RANK_W'(1);
                    if (remain_reg == CW'(1))
                    begin
                        fill_next  = '0;
                        state_next = tks_pkg::S_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = tks_pkg::S_COLLECT;
            end
        endcase

        // a register write empties the store
        if (cfg.valid && cfg.ready)
        begin
            keep_count_next = cfg.data;
            fill_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tks_pkg::S_COLLECT;
            keep_count_reg <= tks_pkg::KEEP_RESET;
            fill_reg       <= '0;
            remain_reg     <= '0;
            rank_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            keep_count_reg <= keep_count_next;
            fill_reg       <= fill_next;
            remain_reg     <= remain_next;
            rank_reg       <= rank_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold result payload
    always_ff @(posedge clk)
    begin
        short_reg     <= short_next;
        out_value_reg <= out_value_next;
        out_rank_reg  <= out_rank_next;
        out_short_reg <= out_short_next;
        out_last_reg  <= out_last_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.kept_value   = out_value_reg;
    assign results.rank         = out_rank_reg;
    assign results.short_stream = out_short_reg;
    assign results.last_result  = out_last_reg;

`ifndef ASSERT_OFF
    // the store never holds more than k values
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= k_eff)
        else $error("store holds more values than k");

    // an end-of-set transaction always starts a non-empty drain
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && samples.end_of_set && !(cfg.valid && cfg.ready)
        |=> state_reg == tks_pkg::S_DRAIN && remain_reg != '0)
        else $error("end of set did not start a drain");

    // draining always has a result left to send
    a_drain_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tks_pkg::S_DRAIN |-> remain_reg != '0)
        else $error("drain with nothing left");

    // a stalled result transaction holds valid and payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready
        |=> results.valid && $stable(results.kept_value) && $stable(results.rank)
            && $stable(results.short_stream) && $stable(results.last_result))
        else $error("stalled result changed");
`endif

endmodule

[sim/tb_streaming_top_k_select.sv]
`timescale 1ns / 100ps
// Self-checking testbench for streaming_top_k_select: directed table, then random sets.
// Depends on tks_pkg and the channel interfaces in tks_ifs.sv.
module tb_streaming_top_k_select;

    localparam int VALUE_W      = tks_pkg::VALUE_W;
    localparam int RANK_W       = tks_pkg::RANK_W;
    localparam int CNT_W        = tks_pkg::CNT_W;
    localparam int MAX_KEEP_DEF = tks_pkg::MAX_KEEP_DEF;
    localparam int RESULT_LIMIT = tks_pkg::RESULT_LIMIT;
    localparam logic [CNT_W-1:0] KEEP_RESET = tks_pkg::KEEP_RESET;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_NS      = 5_000_000;
    localparam int ITEM_TARGET   = 280;
    localparam int QUIET_FROM    = 240;
    localparam int REPORT_LIMIT  = 10;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [RANK_W-1:0]         rank;
        logic                      short_set;
        logic                      last;
    } ranked_value_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE_K
    } row_kind_t;

    typedef enum logic [1:0] {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EDGES
    } value_style_t;

    typedef struct {
        row_kind_t                 kind;
        logic signed [VALUE_W-1:0] value;
        logic                      eos;
        bit                        typed;
        ranked_value_t             want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tks_sample_if sample_ch ();
    tks_result_if result_ch ();
    tks_cfg_if    keep_ch ();

    // top-k store as the block should hold it
    logic signed [VALUE_W-1:0] top_store [MAX_KEEP_DEF];
    int unsigned               top_fill;
    logic [CNT_W-1:0]          keep_reg;

    ranked_value_t ranked_queue[$];
    stim_row_t     directed_rows[$];

    int  mismatch_count     = 0;
    int  results_checked    = 0;
    int  samples_sent       = 0;
    int  sets_closed        = 0;
    int  writes_done        = 0;
    int  result_hold_cycles = 0;
    bit  sample_gaps_on     = 1'b0;
    bit  result_stalls_on   = 1'b0;

    streaming_top_k_select DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (keep_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic ranked_value_t ranked(input logic signed [VALUE_W-1:0] v,
                                             input int unsigned r, input logic s,
                                             input logic l);
        ranked_value_t rv;
        rv.value     = v;
        rv.rank      = RANK_W'(r);
        rv.short_set = s;
        rv.last      = l;
        return rv;
    endfunction

    function automatic stim_row_t stim_row(input row_kind_t kind,
                                           input logic signed [VALUE_W-1:0] v,
                                           input logic eos, input bit typed,
                                           input ranked_value_t want);
        stim_row_t row;
        row.kind  = kind;
        row.value = v;
        row.eos   = eos;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // Append one expected result at the tail of the queue.
    function automatic void queue_expected(input ranked_value_t rv);
        ranked_queue.insert(ranked_queue.size(), rv);
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Clamp the register to the number of values actually kept.
    function automatic int unsigned k_in_force(input logic [CNT_W-1:0] k);
        int unsigned eff;
        eff = (k == 0) ? 1 : k;
        if (eff > MAX_KEEP_DEF)
            eff = MAX_KEEP_DEF;
        if (eff > RESULT_LIMIT)
            eff = RESULT_LIMIT;
        return eff;
    endfunction

    // Insert into the descending list of length len, shifting smaller ones down.
    function automatic void insert_ranked(input logic signed [VALUE_W-1:0] v,
                                          input int unsigned len);
        int pos;
        pos = len;
        while (pos > 0 && top_store[pos - 1] < v)
        begin
            top_store[pos] = top_store[pos - 1];
            pos--;
        end
        top_store[pos] = v;
    endfunction

    // Take one sample into the store; on end of set, queue the ranked readout.
    function automatic void absorb_sample(input logic signed [VALUE_W-1:0] v,
                                          input logic eos, input bit publish);
        int unsigned k;
        logic        short_set;
        k = k_in_force(keep_reg);
        if (top_fill > k)
            top_fill = k;
        if (top_fill < k)
        begin
            insert_ranked(v, top_fill);
            top_fill++;
        end
        else if (v > top_store[k - 1])
        begin
            insert_ranked(v, k - 1);
        end
        if (eos)
        begin
            short_set = (top_fill < k);
            if (publish)
                for (int unsigned i = 0; i < top_fill; i++)
                    queue_expected(ranked(top_store[i], i, short_set, i + 1 == top_fill));
            top_fill = 0;
        end
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value(input value_style_t style);
        case (style)
            SPREAD_FULL:   return $urandom;
            SPREAD_NARROW: return $signed($urandom_range(0, 15)) - 8;
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return 0;
                    3:       return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_keep();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return CNT_W'($urandom_range(MAX_KEEP_DEF + 1, 31));
        if (r == 1)
            return '0;
        return CNT_W'($urandom_range(1, MAX_KEEP_DEF));
    endfunction

    // Drop valid and hold the sample channel idle for a span set by n (n >= 1).
    task automatic pause_samples(input int n);
        sample_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Wait for every expected result, then let the chain settle.
    task automatic await_results_drained();
        while (ranked_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one sample and hold it until the block takes the transaction.
    task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic eos,
                             input bit typed, input ranked_value_t want);
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= v;
        sample_ch.end_of_set   <= eos;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        absorb_sample(v, eos, !typed);
        if (typed)
            queue_expected(want);
        samples_sent++;
        if (eos)
            sets_closed++;
        if (sample_gaps_on && $urandom_range(0, 3) == 0)
            pause_samples($urandom_range(1, 8));
    endtask

    // Write keep_count only once the block has gone idle.
    task automatic write_keep_count(input logic [CNT_W-1:0] k);
        pause_samples(1);
        await_results_drained();
        keep_ch.valid <= 1'b1;
        keep_ch.data  <= k;
        @(posedge clk);
        while (!keep_ch.ready)
            @(posedge clk);
        keep_ch.valid <= 1'b0;
        keep_reg = k;
        top_fill = 0;
        writes_done++;
    endtask

    task automatic send_set(input int len, input value_style_t style);
        for (int i = 0; i < len; i++)
            send_item(pick_value(style), i == len - 1, 1'b0, '0);
    endtask

    // Drive result ready: a requested long hold takes priority, then random stall bursts.
    initial
    begin : result_ready_driver
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_hold_cycles > 0)
            begin
                result_hold_cycles--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (result_stalls_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin : result_checker
        ranked_value_t got;
        ranked_value_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            got = ranked(result_ch.kept_value, result_ch.rank, result_ch.short_stream,
                         result_ch.last_result);
            if (ranked_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result value %0d rank %0d short %0b last %0b",
                             $realtime, got.value, got.rank, got.short_set, got.last);
            end
            else
            begin
                want = ranked_queue.pop_front();
                results_checked++;
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: exp %0d r%0d s%0b l%0b, got %0d r%0d s%0b l%0b",
                                 $realtime, want.value, want.rank, want.short_set,
                                 want.last, got.value, got.rank, got.short_set, got.last);
                end
            end
        end
    end

    // Main stimulus: reset, directed table, random sets, quiet tail.
    initial
    begin : stimulus
        int           len;
        int           k_eff;
        int           r;
        bit           pressure_done;
        value_style_t style;

        pressure_done = 1'b0;
        keep_reg      = KEEP_RESET;
        top_fill      = 0;

        rst_n                  <= 1'b0;
        sample_ch.valid        <= 1'b0;
        sample_ch.sample_value <= '0;
        sample_ch.end_of_set   <= 1'b0;
        keep_ch.valid          <= 1'b0;
        keep_ch.data           <= KEEP_RESET;

        // after reset k is 16, so a single value is a short set
        add_row(stim_row(ROW_SAMPLE, 5, 1'b1, 1'b1, ranked(5, 0, 1'b1, 1'b1)));
        add_row(stim_row(ROW_WRITE_K, 1, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, VAL_MAX, 1'b1, 1'b1, ranked(VAL_MAX, 0, 1'b0, 1'b1)));
        // a tie with the smallest kept value changes nothing
        add_row(stim_row(ROW_SAMPLE, VAL_MIN, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, VAL_MIN, 1'b1, 1'b1, ranked(VAL_MIN, 0, 1'b0, 1'b1)));
        add_row(stim_row(ROW_SAMPLE, -1, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 0, 1'b1, 1'b1, ranked(0, 0, 1'b0, 1'b1)));
        // zero count acts as one
        add_row(stim_row(ROW_WRITE_K, 0, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 7, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 3, 1'b1, 1'b1, ranked(7, 0, 1'b0, 1'b1)));
        // oversized count is clamped to 16
        add_row(stim_row(ROW_WRITE_K, 31, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 1, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 2, 1'b1, 1'b0, '0));
        // ties and replacement of the smallest
        add_row(stim_row(ROW_WRITE_K, 3, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 10, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, -5, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 10, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 20, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 10, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, -5, 1'b1, 1'b0, '0));
        // a write in the middle of a set empties the store
        add_row(stim_row(ROW_WRITE_K, 16, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 100, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 200, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_WRITE_K, 2, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 1, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 2, 1'b0, 1'b0, '0));
        add_row(stim_row(ROW_SAMPLE, 3, 1'b1, 1'b0, '0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table with light idling on both sides.
        sample_gaps_on   = 1'b1;
        result_stalls_on = 1'b1;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE_K)
                write_keep_count(directed_rows[i].value[CNT_W-1:0]);
            else
                send_item(directed_rows[i].value, directed_rows[i].eos,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // Random sets until the item budget is spent.
        while (samples_sent < ITEM_TARGET)
        begin
            if (samples_sent < QUIET_FROM)
            begin
                sample_gaps_on   = ($urandom_range(0, 3) != 0);
                result_stalls_on = ($urandom_range(0, 3) != 0);
            end
            else
            begin
                sample_gaps_on   = 1'b0;
                result_stalls_on = 1'b0;
            end

            // Hold off the receiver while the sender keeps offering.
            if (!pressure_done && samples_sent >= 120)
            begin
                pressure_done = 1'b1;
                write_keep_count(MAX_KEEP_DEF);
                sample_gaps_on     = 1'b0;
                result_hold_cycles = 120;
                send_set(MAX_KEEP_DEF, SPREAD_FULL);
                for (int i = 0; i < 10; i++)
                    send_item(pick_value(SPREAD_FULL), 1'b0, 1'b0, '0);
                send_item(pick_value(SPREAD_FULL), 1'b1, 1'b0, '0);
                // offered while the drain is held up by the receiver
                send_item(pick_value(SPREAD_FULL), 1'b0, 1'b0, '0);
                pause_samples(1);
                await_results_drained();
            end

            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                // broken set: cut short by a register write
                len = $urandom_range(2, 7);
                for (int i = 0; i < len; i++)
                    send_item(pick_value(SPREAD_FULL), 1'b0, 1'b0, '0);
                write_keep_count(pick_keep());
            end
            else if (r < 3)
            begin
                write_keep_count(pick_keep());
            end
            else if (r == 3)
            begin
                pause_samples(1);
                await_results_drained();
            end

            k_eff = k_in_force(keep_reg);
            style = value_style_t'($urandom_range(0, 2));
            r     = $urandom_range(0, 9);
            if (r < 3)
                len = $urandom_range(1, k_eff);
            else if (r < 9)
                len = k_eff + $urandom_range(0, 10);
            else
                len = $urandom_range(20, 40);
            send_set(len, style);
        end

        // Drain everything that is still in flight.
        sample_gaps_on   = 1'b0;
        result_stalls_on = 1'b0;
        pause_samples(1);
        await_results_drained();

        $display("Ran %0d samples in %0d sets with %0d keep_count writes (0, 1..16, clamped).",
                 samples_sent, sets_closed, writes_done);
        $display("Checked %0d ranked results, %0d mismatches.", results_checked,
                 mismatch_count);
        if (mismatch_count == 0 && ranked_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Stop a hung run.
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("Timeout with %0d results still expected.", ranked_queue.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/tks_pkg.sv
rtl/core/tks_ifs.sv
rtl/core/tks_cell.sv
rtl/core/streaming_top_k_select.sv
sim/tb_streaming_top_k_select.sv
